@@ rtl/core/srrip_pkg.sv @@
`timescale 1ns / 1ps
package srrip_pkg;
    localparam int RRPV_W = 2;
    localparam logic [RRPV_W-1:0] RRPV_TOP = 2'd3;
    localparam logic [1:0] CTR_TOP = 2'd3;
    localparam logic [1:0] CODE_NONE = 2'd0;
    localparam logic [1:0] CODE_POS = 2'd1;
    localparam logic [1:0] CODE_NEG = 2'd2;
    localparam logic [0:0] OP_VICTIM = 1'b0;
    localparam logic [0:0] OP_ACCESS = 1'b1;

    typedef enum logic [1:0] {
        KIND_FOLLOW = 2'd0,
        KIND_LIP    = 2'd1,
        KIND_DRRIP  = 2'd2
    } leader_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;      // clearing pass step
        logic capture;    // latch input item
        logic execute;    // memories have been read, compute and write back
        logic train;      // age out the replaced way's old signature
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
    } dp_stat_t;
endpackage

@@ rtl/core/ship_stream_bypass_rrip_replacement_core.sv @@
`timescale 1ns / 1ps
// Replacement engine (RRIP + PC-signature reuse + stream bypass + set dueling).
// Each item passes the capture, execute and train steps: the accept edge reads
// the set's rows and the reuse counter of the new signature; the execute edge
// computes, writes back, loads the result register and reads the counter of the
// replaced way's old signature; the train edge decrements that counter after a
// normal fill. A new item is taken only once the block is idle again, so items
// do not overlap, and a result held by out_stall keeps the input stalled. After
// reset a clearing pass over max(NUM_SETS, SIG_ENTRIES) addresses initializes
// the memories, during which no item is accepted. Write stream_threshold only
// while no item is in flight.
module ship_stream_bypass_rrip_replacement_core #(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int SIG_ENTRIES   = 64,
    parameter int DELTA_DEPTH   = 4,
    parameter int LEADER_COUNT  = 64,
    parameter int SELECTOR_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [10:0] set_index,
    input  logic [3:0]  way,
    input  logic        hit,
    input  logic [63:0] address,
    input  logic [8:0]  pc_low,
    input  logic [4:0]  random_draw,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  victim,
    output logic        bypass
);
    import srrip_pkg::*;

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic [2:0] thr_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) thr_reg <= 3'd3;
        else if (cfg_valid) thr_reg <= cfg_data;
    end

    srrip_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    srrip_datapath #(
        .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_ENTRIES(SIG_ENTRIES),
        .DELTA_DEPTH(DELTA_DEPTH), .LEADER_COUNT(LEADER_COUNT),
        .SELECTOR_BITS(SELECTOR_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .stream_threshold(thr_reg), .opcode(opcode), .set_index(set_index),
        .way(way), .hit(hit), .address(address), .pc_low(pc_low),
        .random_draw(random_draw), .res_victim(victim), .res_bypass(bypass)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.clear, cmd.capture, cmd.execute, cmd.train}) <= 1)
        else $error("conflicting datapath commands");
    a_exec_after_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute)
        else $error("execute did not follow capture");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid)
        else $error("result not presented");
    a_victim_no_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bypass |-> victim == 4'd0)
        else $error("bypass with victim");
endmodule

@@ rtl/core/srrip_datapath.sv @@
`timescale 1ns / 1ps
module srrip_datapath #(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int SIG_ENTRIES   = 64,
    parameter int DELTA_DEPTH   = 4,
    parameter int LEADER_COUNT  = 64,
    parameter int SELECTOR_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  srrip_pkg::dp_cmd_t    cmd,
    output srrip_pkg::dp_stat_t   stat,
    input  logic [2:0]            stream_threshold,
    input  logic                  opcode,
    input  logic [10:0]           set_index,
    input  logic [3:0]            way,
    input  logic                  hit,
    input  logic [63:0]           address,
    input  logic [8:0]            pc_low,
    input  logic [4:0]            random_draw,
    output logic [3:0]            res_victim,
    output logic                  res_bypass
);
    import srrip_pkg::*;

    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int SIG_W  = $clog2(SIG_ENTRIES);
    localparam int PTR_W  = $clog2(DELTA_DEPTH);
    localparam int CNT_W  = $clog2(DELTA_DEPTH + 1);
    localparam int SPAN   = NUM_SETS / LEADER_COUNT;
    localparam int HALF   = NUM_SETS / 2;
    localparam int SPAN_W = $clog2(SPAN);
    localparam int CLR_N  = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int CLR_XW = CLR_W + 1;
    localparam logic [SELECTOR_BITS-1:0] SEL_TOP = '1;
    localparam logic [SELECTOR_BITS-1:0] SEL_MID = SEL_TOP >> 1;

    typedef logic [NUM_WAYS-1:0][RRPV_W-1:0] rrpv_row_t;
    typedef logic [NUM_WAYS-1:0][SIG_W-1:0]  sig_row_t;
    typedef struct packed {
        logic                      valid;
        logic [63:0]               last;
        logic [DELTA_DEPTH-1:0][1:0] signs;
        logic [PTR_W-1:0]          ptr;
    } set_meta_t;

    // per-set memories, one row read and written per item
    rrpv_row_t rrpv_mem [NUM_SETS];
    sig_row_t  sig_mem  [NUM_SETS];
    set_meta_t meta_mem [NUM_SETS];
    // reuse counters, one read and one write per cycle
    logic [1:0] ctr_mem [SIG_ENTRIES];

    rrpv_row_t rrpv_rd_reg;
    sig_row_t  sig_rd_reg;
    set_meta_t meta_rd_reg;
    logic [1:0] ctr_rd_reg;

    logic [SELECTOR_BITS-1:0] psel_reg;
    logic [CLR_W-1:0] clr_addr_reg;

    logic             op_reg, hit_reg;
    logic [SET_W-1:0] set_reg;
    logic [WAY_W-1:0] way_reg;
    logic [63:0]      addr_reg;
    logic [SIG_W-1:0] sig_reg;
    logic [4:0]       draw_reg;
    logic [SIG_W-1:0] old_sig_reg;
    logic             dec_reg;

    logic [SET_W-1:0] set_in;
    logic [WAY_W-1:0] way_in;
    logic [SIG_W-1:0] sig_in;
    logic [SET_W-1:0] clr_set;
    logic [SIG_W-1:0] clr_sig;
    assign set_in = SET_W'(set_index);
    assign way_in = WAY_W'(way);
    assign clr_set = SET_W'(clr_addr_reg);
    assign clr_sig = SIG_W'(clr_addr_reg);

    logic [SET_W-1:0] rd_set;
    assign rd_set = cmd.clear ? clr_set : set_in;

    logic [8:0] pc_mix;
    assign pc_mix = pc_low ^ (pc_low >> 3);
    assign sig_in = SIG_W'(pc_mix);

    // victim path
    logic [RRPV_W-1:0] top;
    rrpv_row_t         aged;
    logic [WAY_W-1:0]  vic;
    always_comb
    begin
        top = '0;
        for (int w = 0; w < NUM_WAYS; w++)
            if (rrpv_rd_reg[w] > top) top = rrpv_rd_reg[w];
        for (int w = 0; w < NUM_WAYS; w++)
            aged[w] = rrpv_rd_reg[w] + (RRPV_TOP - top);
        vic = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
            if (aged[w] == RRPV_TOP) vic = WAY_W'(w);
    end

    // stream tracking
    set_meta_t meta_new;
    logic [63:0] delta;
    logic [1:0]  code;
    logic [CNT_W-1:0] pos_cnt, neg_cnt;
    logic streaming;
    always_comb
    begin
        delta = addr_reg - meta_rd_reg.last;
        code = (delta == 64'd0) ? CODE_NONE : (delta[63] ? CODE_NEG : CODE_POS);
        meta_new = meta_rd_reg;
        if (meta_rd_reg.valid)
        begin
            meta_new.signs[meta_rd_reg.ptr] = code;
            meta_new.ptr = (meta_rd_reg.ptr == PTR_W'(DELTA_DEPTH - 1)) ? '0
                         : meta_rd_reg.ptr + 1'b1;
        end
        meta_new.last = addr_reg;
        meta_new.valid = 1'b1;
        pos_cnt = '0;
        neg_cnt = '0;
        for (int i = 0; i < DELTA_DEPTH; i++)
        begin
            if (meta_new.signs[i] == CODE_POS) pos_cnt = pos_cnt + 1'b1;
            else if (meta_new.signs[i] == CODE_NEG) neg_cnt = neg_cnt + 1'b1;
        end
        streaming = ({1'b0, pos_cnt} >= 4'(stream_threshold))
                 || ({1'b0, neg_cnt} >= 4'(stream_threshold));
    end

    leader_kind_t kind;
    always_comb
    begin
        kind = KIND_FOLLOW;
        if (set_reg[SPAN_W-1:0] == '0)
            kind = (set_reg < SET_W'(HALF)) ? KIND_LIP : KIND_DRRIP;
    end

    logic [SIG_W-1:0] old_sig;
    logic [1:0]       new_rrpv;
    logic             lip;
    assign old_sig = sig_rd_reg[way_reg];
    assign lip = (kind == KIND_LIP) || (kind == KIND_FOLLOW && psel_reg >= SEL_MID);
    always_comb
    begin
        if (ctr_rd_reg >= CTR_TOP - 2'd1) new_rrpv = 2'd0;
        else if (lip) new_rrpv = RRPV_TOP;
        else new_rrpv = (draw_reg == 5'd0) ? RRPV_TOP - 2'd1 : RRPV_TOP;
    end

    // counter read: new signature at capture, old signature during execute
    logic [SIG_W-1:0] rd_sig;
    assign rd_sig = cmd.execute ? old_sig : sig_in;

    rrpv_row_t rrpv_wr;
    sig_row_t  sig_wr;
    always_comb
    begin
        rrpv_wr = rrpv_rd_reg;
        sig_wr = sig_rd_reg;
        if (op_reg == OP_VICTIM)
            rrpv_wr = aged;
        else if (hit_reg)
            rrpv_wr[way_reg] = 2'd0;
        else
        begin
            rrpv_wr[way_reg] = streaming ? RRPV_TOP : new_rrpv;
            sig_wr[way_reg] = sig_reg;
        end
    end

    assign stat.clear_done = (clr_addr_reg == CLR_W'(CLR_N - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            if ({1'b0, clr_addr_reg} < CLR_XW'(NUM_SETS))
            begin
                rrpv_mem[clr_set] <= {NUM_WAYS{RRPV_TOP}};
                sig_mem[clr_set] <= '0;
                meta_mem[clr_set] <= '0;
            end
            if ({1'b0, clr_addr_reg} < CLR_XW'(SIG_ENTRIES))
                ctr_mem[clr_sig] <= '0;
        end
        else if (cmd.execute)
        begin
            rrpv_mem[set_reg] <= rrpv_wr;
            if (op_reg == OP_ACCESS)
            begin
                sig_mem[set_reg] <= sig_wr;
                meta_mem[set_reg] <= meta_new;
                if (hit_reg && ctr_rd_reg < CTR_TOP)
                    ctr_mem[sig_reg] <= ctr_rd_reg + 1'b1;
            end
        end
        else if (cmd.train && dec_reg && ctr_rd_reg != '0)
            ctr_mem[old_sig_reg] <= ctr_rd_reg - 1'b1;
        rrpv_rd_reg <= rrpv_mem[rd_set];
        sig_rd_reg <= sig_mem[rd_set];
        meta_rd_reg <= meta_mem[rd_set];
        ctr_rd_reg <= ctr_mem[rd_sig];
        if (cmd.capture)
        begin
            op_reg <= opcode;
            hit_reg <= hit;
            set_reg <= set_in;
            way_reg <= way_in;
            addr_reg <= address;
            sig_reg <= sig_in;
            draw_reg <= random_draw;
        end
        if (cmd.execute)
        begin
            res_victim <= (op_reg == OP_VICTIM) ? 4'(vic) : 4'd0;
            res_bypass <= (op_reg == OP_ACCESS) && !hit_reg && streaming;
            old_sig_reg <= old_sig;
            dec_reg <= (op_reg == OP_ACCESS) && !hit_reg && !streaming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            psel_reg <= SEL_MID;
        end
        else
        begin
            if (cmd.clear && !stat.clear_done) clr_addr_reg <= clr_addr_reg + 1'b1;
            if (cmd.execute && op_reg == OP_ACCESS && hit_reg)
            begin
                if (kind == KIND_LIP && psel_reg < SEL_TOP) psel_reg <= psel_reg + 1'b1;
                else if (kind == KIND_DRRIP && psel_reg != '0) psel_reg <= psel_reg - 1'b1;
            end
        end
    end
endmodule

@@ rtl/core/srrip_ctrl.sv @@
`timescale 1ns / 1ps
module srrip_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output srrip_pkg::dp_cmd_t  cmd,
    input  srrip_pkg::dp_stat_t stat
);
    import srrip_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_TRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    // new item only when idle and the result register is free or draining this cycle
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.clear = (state_reg == S_CLEAR);
        cmd.capture = accept;
        cmd.execute = (state_reg == S_EXEC);
        cmd.train = (state_reg == S_TRAIN);
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_CLEAR: if (stat.clear_done) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_TRAIN;
                out_valid_next = 1'b1;
            end
            S_TRAIN: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import srrip_pkg::*;

    localparam int SETS = 2048;
    localparam int WAYS = 16;
    localparam int LIMIT = 600000;

    typedef struct {
        logic        op;
        logic [10:0] set_index;
        logic [3:0]  way;
        logic        hit;
        logic [63:0] address;
        logic [8:0]  pc_low;
        logic [4:0]  random_draw;
    } req_t;

    typedef struct {
        logic [3:0] victim;
        logic       bypass;
    } rsp_t;

    class replacement_scoreboard;
        logic [1:0]  rrpv [0:SETS*WAYS-1];
        logic [5:0]  sig_of_way [0:SETS*WAYS-1];
        logic [1:0]  reuse [0:63];
        logic [63:0] prev_addr [0:SETS-1];
        bit          prev_seen [0:SETS-1];
        logic [7:0]  signs [0:SETS-1];
        logic [1:0]  hptr [0:SETS-1];
        logic [9:0]  psel;
        logic [2:0]  threshold;
        rsp_t        pending [$];
        logic [3:0]  last_victim;
        int          mismatches;

        function new();
            for (int i = 0; i < SETS*WAYS; i++) begin
                rrpv[i] = RRPV_TOP;
                sig_of_way[i] = '0;
            end
            for (int i = 0; i < 64; i++) reuse[i] = '0;
            for (int i = 0; i < SETS; i++) begin
                prev_addr[i] = '0;
                prev_seen[i] = 0;
                signs[i] = '0;
                hptr[i] = '0;
            end
            psel = 10'd511;
            threshold = 3'd3;
            mismatches = 0;
        endfunction

        function leader_kind_t kind_of(logic [10:0] s);
            if (s[4:0] != 0) return KIND_FOLLOW;
            // multiples of 32 in the upper half hit the DRRIP form first
            return s[10] ? KIND_DRRIP : KIND_LIP;
        endfunction

        function logic [3:0] choose_victim(logic [10:0] s);
            logic [1:0] top;
            int base;
            base = s * WAYS;
            top = 0;
            for (int w = 0; w < WAYS; w++)
                if (rrpv[base+w] > top) top = rrpv[base+w];
            if (top < RRPV_TOP)
                for (int w = 0; w < WAYS; w++) rrpv[base+w] = rrpv[base+w] + (RRPV_TOP - top);
            for (int w = 0; w < WAYS; w++)
                if (rrpv[base+w] == RRPV_TOP) return w[3:0];
            return 4'd0;
        endfunction

        function bit track_stream(logic [10:0] s, logic [63:0] a);
            logic [63:0] d;
            logic [1:0] code;
            int npos, nneg;
            if (prev_seen[s]) begin
                d = a - prev_addr[s];
                code = (d == 0) ? CODE_NONE : (d[63] ? CODE_NEG : CODE_POS);
                signs[s][2*hptr[s] +: 2] = code;
                hptr[s] = hptr[s] + 2'd1;
            end
            prev_addr[s] = a;
            prev_seen[s] = 1;
            npos = 0;
            nneg = 0;
            for (int i = 0; i < 4; i++) begin
                if (signs[s][2*i +: 2] == CODE_POS) npos++;
                else if (signs[s][2*i +: 2] == CODE_NEG) nneg++;
            end
            return npos >= threshold || nneg >= threshold;
        endfunction

        function void note_item(req_t r);
            rsp_t e;
            logic [5:0] sg, old;
            int idx;
            leader_kind_t k;
            bit streaming, lip;
            e.victim = 0;
            e.bypass = 0;
            if (r.op == OP_VICTIM) begin
                e.victim = choose_victim(r.set_index);
                last_victim = e.victim;
                pending = {pending, e};
                return;
            end
            sg = r.pc_low[5:0] ^ r.pc_low[8:3];
            idx = r.set_index * WAYS + r.way;
            streaming = track_stream(r.set_index, r.address);
            k = kind_of(r.set_index);
            if (r.hit) begin
                if (reuse[sg] < CTR_TOP) reuse[sg]++;
                rrpv[idx] = 0;
                if (k == KIND_LIP && psel != 10'h3FF) psel++;
                else if (k == KIND_DRRIP && psel != 0) psel--;
            end else if (streaming) begin
                sig_of_way[idx] = sg;
                rrpv[idx] = RRPV_TOP;
                e.bypass = 1;
            end else begin
                if (reuse[sg] >= CTR_TOP - 1) rrpv[idx] = 0;
                else begin
                    lip = (k == KIND_LIP) || (k == KIND_FOLLOW && psel >= 10'd511);
                    if (lip || r.random_draw != 0) rrpv[idx] = RRPV_TOP;
                    else rrpv[idx] = RRPV_TOP - 1;
                end
                old = sig_of_way[idx];
                if (reuse[old] > 0) reuse[old]--;
                sig_of_way[idx] = sg;
            end
            pending = {pending, e};
        endfunction

        function void check_result(logic [3:0] vw, logic bp);
            rsp_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: victim %0d bypass %0d", vw, bp);
                return;
            end
            e = pending.pop_front();
            if (vw !== e.victim || bp !== e.bypass) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: victim exp %0d got %0d, bypass exp %0d got %0d",
                             e.victim, vw, e.bypass, bp);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic        hit;
    logic [63:0] address;
    logic [8:0]  pc_low;
    logic [4:0]  random_draw;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  victim;
    logic        bypass;

    replacement_scoreboard sb;
    bit quiet;
    int cycles;
    int sent;
    int stall_left;

    ship_stream_bypass_rrip_replacement_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .set_index(set_index), .way(way), .hit(hit),
        .address(address), .pc_low(pc_low), .random_draw(random_draw),
        .out_valid(out_valid), .out_stall(out_stall),
        .victim(victim), .bypass(bypass)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        out_stall = 0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 17);
            out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall) sb.check_result(victim, bypass);

    task send_item(input req_t r);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1;
        opcode <= r.op;
        set_index <= r.set_index;
        way <= r.way;
        hit <= r.hit;
        address <= r.address;
        pc_low <= r.pc_low;
        random_draw <= r.random_draw;
        do @(posedge clk); while (in_stall);
        sb.note_item(r);
        sent++;
        @(negedge clk);
    endtask

    task query(input logic [10:0] s);
        req_t r;
        r = '{OP_VICTIM, s, 4'($urandom), 1'($urandom), {$urandom, $urandom},
              9'($urandom), 5'($urandom)};
        send_item(r);
    endtask

    task access(input logic [10:0] s, input logic [3:0] w, input logic h,
                input logic [63:0] a, input logic [8:0] pc, input logic [4:0] draw);
        req_t r;
        r = '{OP_ACCESS, s, w, h, a, pc, draw};
        send_item(r);
    endtask

    // wait for every expected result, then let the block settle
    task drain;
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task write_threshold(input logic [2:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.threshold = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task run_random(input int n);
        logic [10:0] pool_set [0:5];
        logic [63:0] cursor [0:5];
        logic [63:0] stride [0:5];
        logic [8:0]  pcs [0:7];
        int stop, slot, pick;
        logic [4:0] draw;
        for (int i = 0; i < 6; i++) begin
            pool_set[i] = ($urandom_range(0, 2) == 0) ? 11'($urandom_range(0, 63) * 32)
                                                       : 11'($urandom);
            cursor[i] = {$urandom, $urandom};
            stride[i] = $urandom_range(0, 1) ? 64'd64 : -64'd64;
        end
        for (int i = 0; i < 8; i++) pcs[i] = 9'($urandom);
        stop = sent + n;
        while (sent < stop) begin
            slot = $urandom_range(0, 5);
            pick = $urandom_range(0, 99);
            draw = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom);
            if ($urandom_range(0, 15) == 0) stride[slot] = -stride[slot];
            if ($urandom_range(0, 9) != 0) cursor[slot] = cursor[slot] + stride[slot];
            if (pick < 12) begin
                if ($urandom_range(0, 1)) query(11'($urandom));
                else access(11'($urandom), 4'($urandom), 1'($urandom), {$urandom, $urandom},
                            9'($urandom), 5'($urandom));
            end else if (pick < 50) begin
                // victim lookup followed by the fill of that way
                query(pool_set[slot]);
                access(pool_set[slot], sb.last_victim, 1'b0, cursor[slot],
                       pcs[$urandom_range(0, 7)], draw);
            end else begin
                access(pool_set[slot], 4'($urandom), $urandom_range(0, 2) != 0, cursor[slot],
                       pcs[$urandom_range(0, 7)], draw);
            end
        end
    endtask

    initial
    begin
        sb = new();
        quiet = 0;
        cycles = 0;
        sent = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = 0;
        in_valid = 0;
        opcode = OP_VICTIM;
        set_index = 0;
        way = 0;
        hit = 0;
        address = 0;
        pc_low = 0;
        random_draw = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // fresh set, promotion, leader and follower fills
        query(11'd5);
        access(11'd5, 4'd0, 1'b1, 64'd0, 9'h1FF, 5'd31);
        query(11'd5);
        access(11'd0, 4'd15, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 9'd0, 5'd0);
        access(11'd1024, 4'd3, 1'b0, 64'h40, 9'h0AA, 5'd0);
        access(11'd1024, 4'd3, 1'b1, 64'h80, 9'h0AA, 5'd7);
        access(11'd0, 4'd15, 1'b1, 64'h0, 9'd0, 5'd1);
        access(11'd2047, 4'd8, 1'b0, 64'h1000, 9'h155, 5'd31);
        // ascending stream then bypassed fill
        access(11'd7, 4'd1, 1'b0, 64'h100, 9'h012, 5'd0);
        access(11'd7, 4'd2, 1'b0, 64'h140, 9'h012, 5'd0);
        access(11'd7, 4'd3, 1'b0, 64'h180, 9'h012, 5'd0);
        access(11'd7, 4'd4, 1'b0, 64'h1C0, 9'h012, 5'd0);
        access(11'd7, 4'd5, 1'b0, 64'h200, 9'h012, 5'd0);
        // descending through zero, repeated address
        access(11'd9, 4'd0, 1'b0, 64'h80, 9'h101, 5'd3);
        access(11'd9, 4'd1, 1'b0, 64'h0, 9'h101, 5'd3);
        access(11'd9, 4'd2, 1'b0, 64'hFFFF_FFFF_FFFF_FFC0, 9'h101, 5'd3);
        access(11'd9, 4'd3, 1'b0, 64'hFFFF_FFFF_FFFF_FF80, 9'h101, 5'd3);
        access(11'd9, 4'd4, 1'b0, 64'hFFFF_FFFF_FFFF_FF80, 9'h101, 5'd3);
        query(11'd7);
        query(11'd9);
        query(11'd1024);
        query(11'd2047);

        run_random(230);
        write_threshold(3'd1);
        run_random(200);
        write_threshold(3'd4);
        run_random(200);
        write_threshold(3'd0);
        run_random(150);
        write_threshold(3'd7);
        run_random(150);
        write_threshold(3'd2);
        run_random(200);
        quiet = 1;
        run_random(100);

        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
